// ===== design/tun_pkg.sv =====
// Package for the triangle unit normal block: widths, the word handed along
// the cell chain, and the saturation constant. No dependencies.
package tun_pkg;

	localparam int COORD_WIDTH      = 24;
	localparam int NORMAL_FRAC_BITS = 15;

	localparam int CW    = COORD_WIDTH;
	localparam int EW    = CW + 1;                 // edge width, signed
	localparam int PW    = 2 * EW;                 // edge product, signed
	localparam int NW    = PW + 1;                 // cross component, signed
	localparam int MW    = NW;                     // cross magnitude, unsigned
	localparam int LO_W  = (MW + 1) / 2;           // low half for squaring
	localparam int HI_W  = MW - LO_W;
	localparam int SQ_W  = 2 * MW;                 // square of one component
	localparam int SUM_W = SQ_W + 2;               // sum of three squares
	localparam int FB    = NORMAL_FRAC_BITS;
	localparam int OW    = FB + 1;                 // output component width
	localparam int RW    = FB + 2;                 // bits of the root r
	localparam int NCELL = RW;                     // one cell per root bit
	localparam int SH    = 2 * FB + 2;             // scale of target and divisor
	localparam int ACC_W = SUM_W + SH + 2;         // residue width in the cells

	localparam logic [RW-1:0] POS_MAX = RW'((64'd1 << FB) - 64'd1);

	typedef struct packed {
		logic [2:0][ACC_W-1:0] a;     // residue per component
		logic [2:0][ACC_W-1:0] b;     // scaled partial root times divisor
		logic [ACC_W-1:0]      c;     // divisor, scaled for the current bit
		logic [2:0][RW-1:0]    r;     // root bits found so far
		logic [2:0]            neg;   // component sign
		logic                  degen; // zero cross product
	} cell_word_t;

endpackage

// ===== design/triangle_unit_normal_top.sv =====
// Top level of the triangle unit normal block: front end, root cell chain
// and output stage. Depends on tun_pkg, tun_front, tun_cell, tun_back.
//
//  channel | handshake             | word
//  --------+-----------------------+-----------------------------------------
//  input   | in_valid / in_ready   | vertex_{a,b,c}_{x,y,z}, Q16.8 signed
//  output  | out_valid / out_ready | normal_{x,y,z} Q1.15 signed, degenerate
//
// One triangle per cycle sustained while out_ready stays high. A triangle passes
// through the front stages, one root cell per root bit and the output stage.
// Every stage has its own valid bit; ready runs back through the stages, so
// a stalled output only stops the stages behind it once they fill up.
// Reset clears the valid bits only; there is no stored table or clear pass.
module triangle_unit_normal_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tun_pkg::CW-1:0]     vertex_a_x,
	input  logic signed [tun_pkg::CW-1:0]     vertex_a_y,
	input  logic signed [tun_pkg::CW-1:0]     vertex_a_z,
	input  logic signed [tun_pkg::CW-1:0]     vertex_b_x,
	input  logic signed [tun_pkg::CW-1:0]     vertex_b_y,
	input  logic signed [tun_pkg::CW-1:0]     vertex_b_z,
	input  logic signed [tun_pkg::CW-1:0]     vertex_c_x,
	input  logic signed [tun_pkg::CW-1:0]     vertex_c_y,
	input  logic signed [tun_pkg::CW-1:0]     vertex_c_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tun_pkg::OW-1:0]     normal_x,
	output logic signed [tun_pkg::OW-1:0]     normal_y,
	output logic signed [tun_pkg::OW-1:0]     normal_z,
	output logic                              degenerate
);

	logic [8:0][tun_pkg::CW-1:0]  vtx;
	tun_pkg::cell_word_t          chain_w [tun_pkg::NCELL+1];
	logic [tun_pkg::NCELL:0]      chain_v;
	logic [tun_pkg::NCELL:0]      chain_r;
	logic [2:0][tun_pkg::OW-1:0]  nrm;

	assign vtx = {vertex_c_z, vertex_c_y, vertex_c_x,
		vertex_b_z, vertex_b_y, vertex_b_x,
		vertex_a_z, vertex_a_y, vertex_a_x};

	// edges, cross product, sum of squares
	tun_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.vtx       (vtx),
		.out_valid (chain_v[0]),
		.out_ready (chain_r[0]),
		.out_word  (chain_w[0])
	);

	// root bits, most significant first; the divisor shifts down two bits
	// per cell so every cell is the same
	for (genvar k = 0; k < tun_pkg::NCELL; k++) begin : g_cell
		tun_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[k]),
			.in_ready  (chain_r[k]),
			.in_word   (chain_w[k]),
			.out_valid (chain_v[k+1]),
			.out_ready (chain_r[k+1]),
			.out_word  (chain_w[k+1])
		);
	end

	// round half up on r/2, saturate +1.0, apply sign
	tun_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (chain_v[tun_pkg::NCELL]),
		.in_ready   (chain_r[tun_pkg::NCELL]),
		.in_word    (chain_w[tun_pkg::NCELL]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.normal     (nrm),
		.degenerate (degenerate)
	);

	assign normal_x = nrm[0];
	assign normal_y = nrm[1];
	assign normal_z = nrm[2];

`ifndef SYNTHESIS
	// an empty output stage means the whole ready chain is open
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate word with nonzero normal");

	// largest component of a unit vector is at least 1/sqrt(3)
	a_nonzero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
		else $error("zero normal on a proper triangle");
`endif

endmodule

// ===== design/tun_front.sv =====
// Front end: edges, cross product, squares and their sum, six stages.
// Depends on tun_pkg.
module tun_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [8:0][tun_pkg::CW-1:0]         vtx,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tun_pkg::cell_word_t                 out_word
);

	logic [5:0] v_q;
	logic [5:0] en;

	logic signed [tun_pkg::EW-1:0] e1_s1 [3];
	logic signed [tun_pkg::EW-1:0] e2_s1 [3];
	logic signed [tun_pkg::PW-1:0] p_s2 [6];
	logic [tun_pkg::MW-1:0]        mag_s3 [3];
	logic [2:0]                    neg_s3, neg_s4, neg_s5;
	logic [2*tun_pkg::HI_W-1:0]    hh_s4 [3];
	logic [tun_pkg::HI_W+tun_pkg::LO_W-1:0] hl_s4 [3];
	logic [2*tun_pkg::LO_W-1:0]    ll_s4 [3];
	logic [tun_pkg::SQ_W-1:0]      sq_s5 [3];
	tun_pkg::cell_word_t           word_s6;

	logic signed [tun_pkg::NW-1:0] n_c [3];
	logic signed [tun_pkg::EW-1:0] e1_c [3];
	logic signed [tun_pkg::EW-1:0] e2_c [3];
	logic [tun_pkg::SUM_W-1:0]     sum_c;

	always_comb begin
		en[5] = !v_q[5] || out_ready;
		for (int k = 4; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[5];
	assign out_word  = word_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1_c[i] = $signed({vtx[3+i][tun_pkg::CW-1], vtx[3+i]})
				- $signed({vtx[i][tun_pkg::CW-1], vtx[i]});
			e2_c[i] = $signed({vtx[6+i][tun_pkg::CW-1], vtx[6+i]})
				- $signed({vtx[i][tun_pkg::CW-1], vtx[i]});
		end
		for (int i = 0; i < 3; i++) begin
			n_c[i] = tun_pkg::NW'(p_s2[2*i]) - tun_pkg::NW'(p_s2[2*i+1]);
		end
		sum_c = tun_pkg::SUM_W'(sq_s5[0]) + tun_pkg::SUM_W'(sq_s5[1])
			+ tun_pkg::SUM_W'(sq_s5[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int k = 1; k < 6; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0] && in_valid) begin
			e1_s1 <= e1_c;
			e2_s1 <= e2_c;
		end
		if (en[1] && v_q[0]) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
		end
		if (en[2] && v_q[1]) begin
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= n_c[i][tun_pkg::NW-1];
				mag_s3[i] <= n_c[i][tun_pkg::NW-1] ? tun_pkg::MW'(-n_c[i])
					: tun_pkg::MW'(n_c[i]);
			end
		end
		if (en[3] && v_q[2]) begin
			neg_s4 <= neg_s3;
			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= mag_s3[i][tun_pkg::MW-1:tun_pkg::LO_W]
					* mag_s3[i][tun_pkg::MW-1:tun_pkg::LO_W];
				hl_s4[i] <= mag_s3[i][tun_pkg::MW-1:tun_pkg::LO_W]
					* mag_s3[i][tun_pkg::LO_W-1:0];
				ll_s4[i] <= mag_s3[i][tun_pkg::LO_W-1:0] * mag_s3[i][tun_pkg::LO_W-1:0];
			end
		end
		if (en[4] && v_q[3]) begin
			neg_s5 <= neg_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (tun_pkg::SQ_W'(hh_s4[i]) << (2 * tun_pkg::LO_W))
					+ (tun_pkg::SQ_W'(hl_s4[i]) << (tun_pkg::LO_W + 1))
					+ tun_pkg::SQ_W'(ll_s4[i]);
			end
		end
		if (en[5] && v_q[4]) begin
			for (int i = 0; i < 3; i++) begin
				word_s6.a[i] <= tun_pkg::ACC_W'(sq_s5[i]) << tun_pkg::SH;
				word_s6.b[i] <= '0;
				word_s6.r[i] <= '0;
			end
			word_s6.c     <= tun_pkg::ACC_W'(sum_c) << tun_pkg::SH;
			word_s6.neg   <= neg_s5;
			word_s6.degen <= (sq_s5[0] == '0) && (sq_s5[1] == '0) && (sq_s5[2] == '0);
		end
	end

endmodule

// ===== design/tun_cell.sv =====
// One root cell: decides one bit of r = floor(sqrt(T/S)) for all three
// components and hands the rescaled residue on. Depends on tun_pkg.
module tun_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tun_pkg::cell_word_t in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output tun_pkg::cell_word_t out_word
);

	logic                v_q;
	tun_pkg::cell_word_t word_q;
	tun_pkg::cell_word_t nxt;

	always_comb begin
		logic [tun_pkg::ACC_W-1:0] s;
		logic [tun_pkg::ACC_W-1:0] bn;
		logic                      take;
		nxt = in_word;
		for (int i = 0; i < 3; i++) begin
			s    = in_word.b[i] + in_word.c;
			take = in_word.a[i] >= s;
			nxt.a[i] = take ? in_word.a[i] - s : in_word.a[i];
			bn       = take ? in_word.b[i] + (in_word.c << 1) : in_word.b[i];
			nxt.b[i] = bn >> 1;
			nxt.r[i] = {in_word.r[i][tun_pkg::RW-2:0], take};
		end
		nxt.c = in_word.c >> 2;
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) word_q <= nxt;
	end

endmodule

// ===== design/tun_back.sv =====
// Output stage: rounds the root to the unit component, saturates +1.0,
// applies the sign and holds the result word. Depends on tun_pkg.
module tun_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tun_pkg::cell_word_t              in_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0][tun_pkg::OW-1:0]      normal,
	output logic                             degenerate
);

	logic                          v_q;
	logic [2:0][tun_pkg::OW-1:0]   normal_q;
	logic                          degen_q;
	logic [2:0][tun_pkg::OW-1:0]   nrm_c;

	always_comb begin
		logic [tun_pkg::RW:0]   sum;
		logic [tun_pkg::RW-1:0] q;
		logic [tun_pkg::RW-1:0] nq;
		for (int i = 0; i < 3; i++) begin
			sum = {1'b0, in_word.r[i]} + (tun_pkg::RW+1)'(1);
			q   = sum[tun_pkg::RW:1];
			nq  = -q;
			if (in_word.degen) begin
				nrm_c[i] = '0;
			end else if (in_word.neg[i]) begin
				nrm_c[i] = nq[tun_pkg::OW-1:0];
			end else if (q > tun_pkg::POS_MAX) begin
				nrm_c[i] = tun_pkg::POS_MAX[tun_pkg::OW-1:0];
			end else begin
				nrm_c[i] = q[tun_pkg::OW-1:0];
			end
		end
	end

	assign in_ready   = !v_q || out_ready;
	assign out_valid  = v_q;
	assign normal     = normal_q;
	assign degenerate = degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			normal_q <= nrm_c;
			degen_q  <= in_word.degen;
		end
	end

endmodule
